>>> sv/hct_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the compacting handle table.
// No dependencies; the design files refer to this package by scoped names, the sim files import it.
package hct_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int DATA_WIDTH  = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	localparam logic [2:0] OP_NEW       = 3'd0;
	localparam logic [2:0] OP_RD_HANDLE = 3'd1;
	localparam logic [2:0] OP_WR_HANDLE = 3'd2;
	localparam logic [2:0] OP_ERASE     = 3'd3;
	localparam logic [2:0] OP_RD_POS    = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] handle;
		logic [5:0]  position;
		logic [31:0] write_value;
	} hct_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] handle_out;
		logic [31:0] data_out;
		logic [6:0]  entry_count;
	} hct_rsp_t;

	typedef struct packed {
		logic [31:0] handle;
		data_t       data;
	} entry_t;

	typedef enum logic [1:0] {
		FND_READ,
		FND_WRITE,
		FND_NEW
	} fnd_sel_t;

	typedef struct packed {
		logic       load;
		logic       ptr_clr;
		logic       ptr_inc;
		logic       ptr_pos;
		logic       rd_en;
		logic       rd_next;
		logic       wr_new;
		logic       wr_data;
		logic       wr_shift;
		logic       cnt_dec;
		logic       fnd_ld;
		fnd_sel_t   fnd_sel;
		logic       resp;
		logic [1:0] resp_status;
		logic       resp_entry;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       full;
		logic       pos_bad;
		logic       ptr_end;
		logic       shift_end;
		logic       match;
	} dp_stat_t;

endpackage

>>> sv/handle_table_compacting_top.sv
`timescale 1ns / 1ps
// Compacting handle table: one command word in while busy is low, one result word out on done.
// New, bad positions and unused opcodes answer straight from decode; read by position reads
// one entry; handle commands scan from index 0, reading then comparing each entry, and an
// erase then shifts each later entry down one place and lowers the count.
// One word at a time: the next word may start the cycle done is high; done is never held.
// Reset clears count and handle counter; memory contents are left as they are. Depends on
// hct_pkg, hct_ctrl, hct_datapath.
module handle_table_compacting_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hct_pkg::hct_req_t req,
	output logic              done,
	output hct_pkg::hct_rsp_t rsp
);

	hct_pkg::dp_cmd_t  cmd;
	hct_pkg::dp_stat_t stat;

	hct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	hct_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

>>> sv/hct_datapath.sv
`timescale 1ns / 1ps
// Datapath: entry memory, request word, count, handle counter, scan pointer, result.
// Depends on hct_pkg.
module hct_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  hct_pkg::hct_req_t req,
	input  hct_pkg::dp_cmd_t  cmd,
	output hct_pkg::dp_stat_t stat,
	output logic              done,
	output hct_pkg::hct_rsp_t rsp
);

	localparam int CMP_W = hct_pkg::CNT_W + 6;

	hct_pkg::entry_t   mem [hct_pkg::TABLE_DEPTH];
	hct_pkg::entry_t   rd_q;
	hct_pkg::entry_t   found_q;
	hct_pkg::hct_req_t cmd_q;
	hct_pkg::cnt_t     count_q;
	hct_pkg::cnt_t     ptr_q;
	logic [31:0]       next_handle_q;
	logic              done_q;
	hct_pkg::hct_rsp_t rsp_q;

	hct_pkg::idx_t     rd_addr;
	hct_pkg::idx_t     wr_addr;
	hct_pkg::entry_t   wr_entry;
	logic              wr_en;
	hct_pkg::data_t    wv;
	logic [CMP_W-1:0]  ptr_plus1;

	assign wv        = hct_pkg::data_t'(cmd_q.write_value);
	assign ptr_plus1 = CMP_W'(ptr_q) + CMP_W'(1);
	assign rd_addr   = cmd.rd_next ? hct_pkg::idx_t'(ptr_plus1) : ptr_q[hct_pkg::IDX_W-1:0];
	assign wr_en     = cmd.wr_new | cmd.wr_data | cmd.wr_shift;

	always_comb begin
		wr_addr  = ptr_q[hct_pkg::IDX_W-1:0];
		wr_entry = rd_q;
		if (cmd.wr_new) begin
			wr_addr  = count_q[hct_pkg::IDX_W-1:0];
			wr_entry = '{handle: next_handle_q, data: '0};
		end else if (cmd.wr_data) begin
			wr_entry = '{handle: rd_q.handle, data: wv};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.load) begin
			cmd_q <= req;
		end
		if (cmd.fnd_ld) begin
			unique case (cmd.fnd_sel)
				hct_pkg::FND_READ:  found_q <= rd_q;
				hct_pkg::FND_WRITE: found_q <= '{handle: rd_q.handle, data: wv};
				hct_pkg::FND_NEW:   found_q <= '{handle: next_handle_q, data: '0};
				default:            found_q <= rd_q;
			endcase
		end
		if (cmd.resp) begin
			rsp_q.status      <= cmd.resp_status;
			rsp_q.handle_out  <= cmd.resp_entry ? found_q.handle : 32'd0;
			rsp_q.data_out    <= cmd.resp_entry ? 32'(found_q.data) : 32'd0;
			rsp_q.entry_count <= 7'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			next_handle_q <= '0;
			ptr_q         <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= cmd.resp;
			if (cmd.wr_new) begin
				count_q       <= count_q + hct_pkg::cnt_t'(1);
				next_handle_q <= next_handle_q + 32'd1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - hct_pkg::cnt_t'(1);
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_pos) begin
				ptr_q <= hct_pkg::cnt_t'(cmd_q.position);
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + hct_pkg::cnt_t'(1);
			end
		end
	end

	assign stat.opcode    = cmd_q.opcode;
	assign stat.full      = (count_q == hct_pkg::cnt_t'(hct_pkg::TABLE_DEPTH));
	assign stat.pos_bad   = (CMP_W'(cmd_q.position) >= CMP_W'(count_q));
	assign stat.ptr_end   = (ptr_q >= count_q);
	assign stat.shift_end = (ptr_plus1 >= CMP_W'(count_q));
	assign stat.match     = (rd_q.handle == cmd_q.handle);

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

>>> sv/hct_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences decode, linear handle scan, erase compaction, position read and response.
// Depends on hct_pkg.
module hct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hct_pkg::dp_stat_t stat,
	output hct_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_POS_RD,
		S_POS_WAIT,
		S_RESP
	} state_t;

	state_t     state_q, state_d;
	logic       busy_q;
	logic [1:0] status_q, status_d;
	logic       entry_q, entry_d;

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		entry_d  = entry_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				status_d = hct_pkg::ST_OK;
				entry_d  = 1'b0;
				state_d  = S_RESP;
				unique case (stat.opcode)
					hct_pkg::OP_NEW: begin
						if (stat.full) begin
							status_d = hct_pkg::ST_FULL;
						end else begin
							cmd.wr_new  = 1'b1;
							cmd.fnd_ld  = 1'b1;
							cmd.fnd_sel = hct_pkg::FND_NEW;
							entry_d     = 1'b1;
						end
					end
					hct_pkg::OP_RD_HANDLE, hct_pkg::OP_WR_HANDLE, hct_pkg::OP_ERASE: begin
						cmd.ptr_clr = 1'b1;
						state_d     = S_SCAN_RD;
					end
					hct_pkg::OP_RD_POS: begin
						if (stat.pos_bad) begin
							status_d = hct_pkg::ST_RANGE;
						end else begin
							cmd.ptr_pos = 1'b1;
							state_d     = S_POS_RD;
						end
					end
					default: ;
				endcase
			end
			S_SCAN_RD: begin
				if (stat.ptr_end) begin
					status_d = hct_pkg::ST_NOT_FOUND;
					state_d  = S_RESP;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (stat.match) begin
					cmd.fnd_ld = 1'b1;
					entry_d    = 1'b1;
					if (stat.opcode == hct_pkg::OP_WR_HANDLE) begin
						cmd.fnd_sel = hct_pkg::FND_WRITE;
						cmd.wr_data = 1'b1;
						state_d     = S_RESP;
					end else if (stat.opcode == hct_pkg::OP_ERASE) begin
						cmd.fnd_sel = hct_pkg::FND_READ;
						state_d     = S_SHIFT_RD;
					end else begin
						cmd.fnd_sel = hct_pkg::FND_READ;
						state_d     = S_RESP;
					end
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				if (stat.shift_end) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
					state_d     = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.ptr_inc  = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			S_POS_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_POS_WAIT;
			end
			S_POS_WAIT: begin
				cmd.fnd_ld  = 1'b1;
				cmd.fnd_sel = hct_pkg::FND_READ;
				entry_d     = 1'b1;
				state_d     = S_RESP;
			end
			S_RESP: begin
				cmd.resp        = 1'b1;
				cmd.resp_status = status_q;
				cmd.resp_entry  = entry_q;
				state_d         = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			busy_q   <= 1'b0;
			status_q <= hct_pkg::ST_OK;
			entry_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			busy_q   <= (state_d != S_IDLE);
			status_q <= status_d;
			entry_q  <= entry_d;
		end
	end

	assign busy = busy_q;

endmodule

>>> sv/hct_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the compacting handle table, bound to the top level.
// Depends on hct_pkg and handle_table_compacting_top.
module hct_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input hct_pkg::hct_rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted word");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while still busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 32'(rsp.entry_count) <= hct_pkg::TABLE_DEPTH)
		else $error("entry count beyond table depth");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != hct_pkg::ST_OK |->
		rsp.handle_out == 32'd0 && rsp.data_out == 32'd0)
		else $error("error result carries nonzero payload");

endmodule

bind handle_table_compacting_top hct_checker u_hct_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

>>> sim/hct_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class for the compacting handle table: a table predictor and a result check.
// Depends on hct_pkg for the command and result word types and the code constants.
package hct_scoreboard_pkg;
	import hct_pkg::*;

	class hct_scoreboard;
		logic [31:0] tbl_handle [TABLE_DEPTH];
		data_t       tbl_data [TABLE_DEPTH];
		int unsigned fill;
		logic [31:0] handle_ctr;
		logic [31:0] last_gone;
		hct_rsp_t    rsp_fifo [$];
		int unsigned errors;
		int unsigned words_in;
		int unsigned peak_fill;
		int unsigned status_seen [4];

		function new();
			fill = 0;
			handle_ctr = '0;
			last_gone = '1;
			errors = 0;
			words_in = 0;
			peak_fill = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// Applies one command word to the shadow table and returns the result it should give.
		function hct_rsp_t table_step(hct_req_t w);
			hct_rsp_t r;
			int unsigned hit;
			int unsigned i;
			r = '0;
			case (w.opcode)
			OP_NEW: begin
				if (fill >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					tbl_handle[fill] = handle_ctr;
					tbl_data[fill] = '0;
					fill++;
					r.handle_out = handle_ctr;
					handle_ctr = handle_ctr + 32'd1;
				end
			end
			OP_RD_HANDLE, OP_WR_HANDLE, OP_ERASE: begin
				hit = fill;
				for (i = 0; i < fill; i++)
					if (hit == fill && tbl_handle[i] == w.handle) hit = i;
				if (hit == fill) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.handle_out = tbl_handle[hit];
					if (w.opcode == OP_WR_HANDLE) begin
						tbl_data[hit] = w.write_value;
						r.data_out = 32'(tbl_data[hit]);
					end else begin
						r.data_out = 32'(tbl_data[hit]);
					end
					if (w.opcode == OP_ERASE) begin
						for (i = hit; i + 1 < fill; i++) begin
							tbl_handle[i] = tbl_handle[i + 1];
							tbl_data[i] = tbl_data[i + 1];
						end
						fill--;
						last_gone = w.handle;
					end
				end
			end
			OP_RD_POS: begin
				if (w.position >= fill) begin
					r.status = ST_RANGE;
				end else begin
					r.handle_out = tbl_handle[w.position];
					r.data_out = 32'(tbl_data[w.position]);
				end
			end
			default: ;
			endcase
			r.entry_count = 7'(fill);
			return r;
		endfunction

		function void note_word(hct_req_t w);
			rsp_fifo = {rsp_fifo, table_step(w)};
			words_in++;
			if (fill > peak_fill) peak_fill = fill;
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_word(hct_rsp_t got);
			hct_rsp_t want;
			if (rsp_fifo.size() == 0) begin
				errors++;
				$display("%0t ns: result word with none pending, expected none, actual %h",
					$time, got);
				return;
			end
			want = rsp_fifo.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("handle_out", want.handle_out, got.handle_out);
			compare_field("data_out", want.data_out, got.data_out);
			compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
			if (!$isunknown(got.status)) status_seen[got.status]++;
		endfunction

		function int unsigned pending();
			return rsp_fifo.size();
		endfunction

		// Mostly live handles; otherwise stale, not yet issued, or arbitrary.
		function logic [31:0] pick_handle();
			int unsigned r;
			r = $urandom_range(99);
			if (fill != 0 && r < 70) return tbl_handle[$urandom_range(fill - 1)];
			if (r < 80) return last_gone;
			if (r < 90) return handle_ctr;
			return $urandom;
		endfunction

		function logic [5:0] pick_position();
			if (fill != 0 && $urandom_range(99) < 80) return 6'($urandom_range(fill - 1));
			return 6'($urandom_range(63));
		endfunction
	endclass

endpackage

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for handle_table_compacting_top: directed and random command words,
// random sender gaps, checked against the scoreboard. Depends on hct_pkg, hct_scoreboard_pkg.
module tb_top;
	import hct_pkg::*;
	import hct_scoreboard_pkg::*;

	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam int STALL_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 2 * TABLE_DEPTH + 16;
	localparam int RANDOM_WORDS = 1425;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	hct_req_t req;
	logic     done;
	hct_rsp_t rsp;

	hct_scoreboard sb;
	int unsigned   quiet_cycles = 0;
	bit            allow_idle;

	always #5 clk = ~clk;

	handle_table_compacting_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always @(posedge clk) begin
		if (arst_n && done) sb.check_word(rsp);
	end

	// Watchdog: cycles with neither a command nor a result word.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("** handle_table_compacting_top: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic hct_req_t random_word();
		hct_req_t w;
		w.opcode = 3'($urandom_range(7));
		w.handle = $urandom;
		w.position = 6'($urandom_range(63));
		w.write_value = $urandom;
		return w;
	endfunction

	function automatic hct_req_t fixed_word(logic [2:0] op, logic [31:0] h, logic [5:0] pos,
		logic [31:0] val);
		hct_req_t w;
		w.opcode = op;
		w.handle = h;
		w.position = pos;
		w.write_value = val;
		return w;
	endfunction

	// Opcode mix per phase: 0 grow, 1 mixed, 2 shrink, 3 churn near full.
	function automatic logic [2:0] pick_op(int unsigned mode);
		int unsigned r;
		int unsigned p_new;
		int unsigned p_erase;
		case (mode)
		0: begin p_new = 75; p_erase = 5; end
		1: begin p_new = 25; p_erase = 15; end
		2: begin p_new = 8; p_erase = 50; end
		default: begin p_new = 40; p_erase = 20; end
		endcase
		r = $urandom_range(99);
		if (r < p_new) return OP_NEW;
		if (r < p_new + p_erase) return OP_ERASE;
		r = $urandom_range(99);
		if (r < 4) begin
			case ($urandom_range(2))
			0: return OP_SPARE_5;
			1: return OP_SPARE_6;
			default: return OP_SPARE_7;
			endcase
		end
		if (r < 36) return OP_RD_HANDLE;
		if (r < 68) return OP_WR_HANDLE;
		return OP_RD_POS;
	endfunction

	function automatic hct_req_t make_word(int unsigned mode);
		hct_req_t w;
		w = random_word();
		w.opcode = pick_op(mode);
		if (w.opcode inside {OP_RD_HANDLE, OP_WR_HANDLE, OP_ERASE}) w.handle = sb.pick_handle();
		if (w.opcode == OP_RD_POS) w.position = sb.pick_position();
		case ($urandom_range(9))
		0: w.write_value = '0;
		1: w.write_value = '1;
		default: ;
		endcase
		return w;
	endfunction

	task automatic idle_cycle();
		start <= 1'b0;
		req <= random_word();
		@(negedge clk);
	endtask

	task automatic gap();
		if (allow_idle)
			while ($urandom_range(99) < 34) idle_cycle();
	endtask

	task automatic send_word(hct_req_t w);
		gap();
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		sb.note_word(w);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	initial begin
		int unsigned left;
		int unsigned phase;
		int unsigned len;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		allow_idle = 1'b1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table, then three entries, edits, a middle erase, spare opcodes, erase to empty, refill
		send_word(fixed_word(OP_RD_POS, '0, '0, '0));
		send_word(fixed_word(OP_RD_HANDLE, '0, '1, '1));
		send_word(fixed_word(OP_ERASE, '0, '0, '0));
		send_word(fixed_word(OP_WR_HANDLE, '1, '1, '1));
		send_word(fixed_word(OP_NEW, '1, '1, '1));
		send_word(fixed_word(OP_NEW, '0, '0, '0));
		send_word(fixed_word(OP_NEW, 32'h5a5a_5a5a, 6'd17, 32'h1234_5678));
		send_word(fixed_word(OP_WR_HANDLE, 32'd1, '0, '1));
		send_word(fixed_word(OP_RD_HANDLE, 32'd1, '1, '0));
		send_word(fixed_word(OP_WR_HANDLE, 32'd0, '0, '0));
		send_word(fixed_word(OP_WR_HANDLE, 32'd2, '1, 32'ha5a5_a5a5));
		send_word(fixed_word(OP_RD_POS, '1, 6'd2, '1));
		send_word(fixed_word(OP_RD_POS, '0, 6'd3, '0));
		send_word(fixed_word(OP_RD_POS, '0, 6'd63, '0));
		send_word(fixed_word(OP_ERASE, 32'd1, '1, '1));
		send_word(fixed_word(OP_RD_POS, '0, 6'd1, '0));
		send_word(fixed_word(OP_RD_HANDLE, 32'd1, '0, '0));
		send_word(fixed_word(OP_SPARE_5, '1, '1, '1));
		send_word(fixed_word(OP_SPARE_6, '1, '1, '1));
		send_word(fixed_word(OP_SPARE_7, 32'd2, '0, '1));
		send_word(fixed_word(OP_ERASE, 32'd2, '0, '0));
		send_word(fixed_word(OP_ERASE, 32'd0, '1, '1));
		send_word(fixed_word(OP_NEW, '0, '0, '0));
		send_word(fixed_word(OP_RD_POS, '1, 6'd0, '1));
		drain();

		// phases of biased random traffic, drained at each boundary
		left = RANDOM_WORDS;
		phase = 0;
		while (left != 0) begin
			len = $urandom_range(150, 60);
			if (len > left) len = left;
			allow_idle = (phase != 4);
			repeat (len) send_word(make_word(phase % 4));
			left -= len;
			phase++;
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Sent %0d command words over %0d phases; peak table fill %0d of %0d.",
			sb.words_in, phase, sb.peak_fill, TABLE_DEPTH);
		$display("Status counts: ok %0d, not found %0d, full %0d, out of range %0d.",
			sb.status_seen[ST_OK], sb.status_seen[ST_NOT_FOUND],
			sb.status_seen[ST_FULL], sb.status_seen[ST_RANGE]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("** handle_table_compacting_top: PASSED **");
		end else begin
			$display("** handle_table_compacting_top: FAILED **");
		end
		$finish;
	end

endmodule
